@@ design/prb_pkg.sv @@
// Shared types, sizes and codes for the packet reorder buffer.
// Used by every module of the block except prb_ram; depends on nothing.
package prb_pkg;

    // Window store sizing (power of two, slot index is the low seq bits)
    localparam int WINDOW      = 16;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);

    // Field widths
    localparam int SEQ_W       = 32;
    localparam int ID_W        = 32;
    localparam int TAG_W       = 16;
    localparam int OP_W        = 2;
    localparam int GAP_W       = 5;
    localparam int SLOT_DATA_W = ID_W + TAG_W;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(5);
    localparam logic [SEQ_W-1:0] SEQ_MAX   = '1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH  = 2;
    localparam int QPTR_W      = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W      = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PACKET     = 2'd0,
        OP_CONNECT    = 2'd1,
        OP_DISCONNECT = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_RETX    = 2'd1,
        KIND_CLOSE   = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_CONNECT = 1'b0,
        CMD_PACKET  = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [SEQ_W-1:0] seq;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
        logic             close;
    } t_cmd;

    typedef struct packed {
        t_kind            kind;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  from_id;
        logic [ID_W-1:0]  to_id;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DRAIN,
        S_DLV,
        S_SCAN,
        S_REQ,
        S_FIN
    } t_back_state;

endpackage

@@ design/packet_reorder_buffer.sv @@
// Flow: a request enters the command queue at its accepting edge; the back end then takes each
// command through S_EVAL: a connect or dropped packet ends there, a close marker goes to S_FIN,
// a stored packet to S_DRAIN, with S_DLV per released packet and S_SCAN, S_REQ for a retransmit
// request. The sequencer, with its single slot-RAM read port, takes the next command only from
// S_IDLE and result stalls hold it; the 2-entry command queue absorbs short bursts.
// Reset: synchronous, active low; clears all control state, loads gap_threshold with 5.
module packet_reorder_buffer
    import prb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [SEQ_W-1:0] i_seq,
    input  logic [ID_W-1:0]  i_packet_id,
    input  logic [TAG_W-1:0] i_payload_tag,
    input  logic             i_close_marker,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [GAP_W-1:0] i_cfg_gap_threshold,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_kind,
    output logic [SEQ_W-1:0] o_out_seq,
    output logic [TAG_W-1:0] o_out_payload_tag,
    output logic [ID_W-1:0]  o_from_id,
    output logic [ID_W-1:0]  o_to_id,
    output logic             o_last
);

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_cmd    q_wdata;
    t_cmd    q_rdata;
    t_result result;

    // front end: classify and queue
    prb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_opcode       (i_opcode),
        .i_seq          (i_seq),
        .i_packet_id    (i_packet_id),
        .i_payload_tag  (i_payload_tag),
        .i_close_marker (i_close_marker),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    // command queue
    prb_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // back end: store, release, retransmit requests
    prb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_gap_threshold),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result),
        .o_last      (o_last)
    );

    assign o_kind            = result.kind;
    assign o_out_seq         = result.seq;
    assign o_out_payload_tag = result.tag;
    assign o_from_id         = result.from_id;
    assign o_to_id           = result.to_id;

endmodule

@@ design/prb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/prb_front.sv @@
// Front end: accepts requests, tracks connection state, queues commands.
// Depends on prb_pkg.
module prb_front
    import prb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [SEQ_W-1:0] i_seq,
    input  logic [ID_W-1:0]  i_packet_id,
    input  logic [TAG_W-1:0] i_payload_tag,
    input  logic             i_close_marker,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_cmd             o_q_data
);

    logic r_connected;
    logic n_connected;
    logic accept;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // classify: disconnect, unknown opcodes and idle packets end here, the rest go to the back end
    always_comb begin
        n_connected    = r_connected;
        o_q_push       = 1'b0;
        o_q_data.kind  = CMD_PACKET;
        o_q_data.seq   = i_seq;
        o_q_data.id    = i_packet_id;
        o_q_data.tag   = i_payload_tag;
        o_q_data.close = i_close_marker;
        case (t_opcode'(i_opcode))
            OP_PACKET: begin
                o_q_push = accept && r_connected;
            end
            OP_CONNECT: begin
                o_q_data.kind = CMD_CONNECT;
                o_q_push      = accept;
                if (accept) begin
                    n_connected = 1'b1;
                end
            end
            OP_DISCONNECT: begin
                if (accept) begin
                    n_connected = 1'b0;
                end
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connected <= 1'b0;
        end else begin
            r_connected <= n_connected;
        end
    end

endmodule

@@ design/prb_cmdq.sv @@
// Short command queue between front and back end, first-word fall-through.
// Depends on prb_pkg.
module prb_cmdq
    import prb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/prb_back.sv @@
// Back end: window store, in-order release, retransmit request and output register.
// Depends on prb_pkg and prb_ram.
module prb_back
    import prb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_cmd             i_q_data,
    output logic             o_q_pop,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [GAP_W-1:0] i_cfg_data,
    input  logic             i_pop,
    output logic             o_empty,
    output t_result          o_result,
    output logic             o_last
);

    t_back_state       r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [SEQ_W-1:0]  r_dseq, n_dseq;
    logic [ID_W-1:0]   r_did, n_did;
    logic [WINDOW-1:0] r_slot_valid, n_slot_valid;
    logic [CNT_W-1:0]  r_cached, n_cached;
    logic [GAP_W-1:0]  r_gap;
    logic              r_seen, n_seen;
    logic [SEQ_W-1:0]  r_key_lost, n_key_lost;
    logic [ID_W-1:0]   r_key_from, n_key_from;
    logic [ID_W-1:0]   r_key_to, n_key_to;
    logic [SLOT_W-1:0] r_scan_idx, n_scan_idx;
    logic              r_pend_valid, n_pend_valid;
    t_result           r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic              r_out_last, n_out_last;

    // slot RAM: {id, tag}
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [SLOT_DATA_W-1:0] ram_wdata;
    logic                   ram_re;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [SLOT_DATA_W-1:0] ram_rdata;
    logic [ID_W-1:0]        rd_id;
    logic [TAG_W-1:0]       rd_tag;

    logic [SEQ_W-1:0]  nx;
    logic [SLOT_W-1:0] nx_slot;
    logic [SLOT_W-1:0] in_slot;
    logic [SEQ_W-1:0]  ahead;
    logic              out_free;
    logic              same_req;

    prb_ram #(
        .WIDTH (SLOT_DATA_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[SLOT_DATA_W-1:TAG_W];
    assign rd_tag   = ram_rdata[TAG_W-1:0];
    assign nx       = r_dseq + 1'b1;
    assign nx_slot  = nx[SLOT_W-1:0];
    assign in_slot  = r_cmd.seq[SLOT_W-1:0];
    assign ahead    = r_cmd.seq - r_dseq - 1'b1;
    assign out_free = !r_out_valid || i_pop;
    assign same_req = r_seen && (r_key_lost == nx) && (r_key_from == r_did)
                      && (r_key_to == rd_id);

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_cfg_ready = 1'b1;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;
    assign o_last      = r_out_last;

    // sequencer: next state, store updates and result hand-off
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_dseq       = r_dseq;
        n_did        = r_did;
        n_slot_valid = r_slot_valid;
        n_cached     = r_cached;
        n_seen       = r_seen;
        n_key_lost   = r_key_lost;
        n_key_from   = r_key_from;
        n_key_to     = r_key_to;
        n_scan_idx   = r_scan_idx;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_pop;
        n_out        = r_out;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = in_slot;
        ram_wdata    = {r_cmd.id, r_cmd.tag};
        ram_re       = 1'b0;
        ram_raddr    = nx_slot;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_cmd   = i_q_data;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (r_cmd.kind == CMD_CONNECT) begin
                    n_dseq       = '0;
                    n_did        = '0;
                    n_slot_valid = '0;
                    n_cached     = '0;
                end else if (r_cmd.seq <= r_dseq) begin
                    // duplicate, dropped
                    n_state = S_IDLE;
                end else if (r_cmd.close) begin
                    n_pend_valid = 1'b1;
                    n_pend       = '{kind: KIND_CLOSE, seq: '0, tag: '0,
                                     from_id: '0, to_id: '0};
                    n_state      = S_FIN;
                end else if (ahead < SEQ_W'(WINDOW)) begin
                    ram_we = 1'b1;
                    if (!r_slot_valid[in_slot]) begin
                        n_cached = r_cached + 1'b1;
                    end
                    n_slot_valid[in_slot] = 1'b1;
                    n_state               = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_dseq != SEQ_MAX && r_slot_valid[nx_slot]) begin
                    ram_re                = 1'b1;
                    n_slot_valid[nx_slot] = 1'b0;
                    n_cached              = r_cached - 1'b1;
                    n_state               = S_DLV;
                end else if (r_cached != '0 && 32'(r_cached) > 32'(r_gap)) begin
                    n_scan_idx = nx_slot;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DLV: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend       = '{kind: KIND_DELIVER, seq: nx, tag: rd_tag,
                                     from_id: '0, to_id: '0};
                    n_dseq       = nx;
                    n_did        = rd_id;
                    n_state      = S_DRAIN;
                end
            end
            S_SCAN: begin
                // lowest cached seq: walk slots upward from the next expected one
                if (r_slot_valid[r_scan_idx]) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_scan_idx;
                    n_state   = S_REQ;
                end else begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            S_REQ: begin
                if (same_req) begin
                    n_state = S_FIN;
                end else if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend       = '{kind: KIND_RETX, seq: nx, tag: '0,
                                     from_id: r_did, to_id: rd_id};
                    n_seen       = 1'b1;
                    n_key_lost   = nx;
                    n_key_from   = r_did;
                    n_key_to     = rd_id;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                // final result of the item carries the last mark
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dseq       <= '0;
            r_did        <= '0;
            r_slot_valid <= '0;
            r_cached     <= '0;
            r_seen       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_gap        <= GAP_RESET;
        end else begin
            r_dseq       <= n_dseq;
            r_did        <= n_did;
            r_slot_valid <= n_slot_valid;
            r_cached     <= n_cached;
            r_seen       <= n_seen;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_gap <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key_lost <= n_key_lost;
        r_key_from <= n_key_from;
        r_key_to   <= n_key_to;
        r_scan_idx <= n_scan_idx;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // cached count tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cached == CNT_W'($countones(r_slot_valid)))
        else $error("cached count out of step with slot valid bits");

    // slot scan only starts with something cached
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cached != '0)
        else $error("slot scan with empty window");

    // no held result may survive into the next item
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_valid)
        else $error("held result left over at idle");

    // each release advances the delivered seq by exactly one
    a_release_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLV && n_state == S_DRAIN) |=> r_dseq == $past(r_dseq) + 1'b1)
        else $error("delivered seq did not step by one");

endmodule
